### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define RBCX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define RBCX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rbcx_pkg.sv
package rbcx_pkg;

    localparam int WORD_W = 32;
    localparam int ROWS   = 32;
    localparam int COLS   = 32;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Column update issued when a word is accepted.
    typedef struct packed {
        logic              valid;
        logic [COL_W-1:0]  addr;
        logic [WORD_W-1:0] word;
    } upd_req_t;

    // Read of one column entry during a flush.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] addr;
    } flush_req_t;

    // Column value returned in the cycle after a flush read.
    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] data;
    } flush_rsp_t;

endpackage

### rtl/rbcx_col_store.sv
// Column XOR store: one synchronous memory with a registered read, updated
// by read-modify-write. A flush read returns an entry and marks it empty.
module rbcx_col_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rbcx_pkg::upd_req_t    upd,
    input  rbcx_pkg::flush_req_t  fl_req,
    output rbcx_pkg::flush_rsp_t  fl_rsp
);

    logic [rbcx_pkg::WORD_W-1:0] mem_reg [rbcx_pkg::COLS];
    logic [rbcx_pkg::COLS-1:0]   vld_reg;

    logic [rbcx_pkg::WORD_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;

    logic                        s1_valid_reg;
    logic                        s1_flush_reg;
    logic [rbcx_pkg::COL_W-1:0]  s1_addr_reg;
    logic [rbcx_pkg::WORD_W-1:0] s1_word_reg;

    logic                        wb_valid_reg;
    logic [rbcx_pkg::COL_W-1:0]  wb_addr_reg;
    logic [rbcx_pkg::WORD_W-1:0] wb_data_reg;

    logic                        rd_en;
    logic [rbcx_pkg::COL_W-1:0]  rd_addr;
    logic [rbcx_pkg::WORD_W-1:0] rd_value;
    logic [rbcx_pkg::WORD_W-1:0] old_value;
    logic [rbcx_pkg::WORD_W-1:0] new_value;

    assign rd_en   = upd.valid | fl_req.valid;
    assign rd_addr = upd.valid ? upd.addr : fl_req.addr;

    // An entry that was never written since the last flush reads as zero.
    assign rd_value = rd_vld_reg ? rd_data_reg : '0;

    // The write of the previous cycle is not yet visible in the read data.
    assign old_value = (wb_valid_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : rd_value;
    assign new_value = old_value ^ s1_word_reg;

    assign fl_rsp.valid = s1_flush_reg;
    assign fl_rsp.data  = rd_value;

    always_ff @(posedge clk) begin
        if (s1_valid_reg) begin
            mem_reg[s1_addr_reg] <= new_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
        s1_addr_reg <= upd.addr;
        s1_word_reg <= upd.word;
        wb_addr_reg <= s1_addr_reg;
        wb_data_reg <= new_value;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
        end
        else begin
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (s1_valid_reg) begin
                vld_reg[s1_addr_reg] <= 1'b1;
            end
            if (fl_req.valid) begin
                vld_reg[fl_req.addr] <= 1'b0;
            end
            s1_valid_reg <= upd.valid;
            s1_flush_reg <= fl_req.valid & ~upd.valid;
            wb_valid_reg <= s1_valid_reg;
        end
    end

endmodule

### rtl/block_row_column_xor_checksum_unit.sv
// Row and column XOR checksum over a stream of 32-bit words.
// Input beats on the s_ channel carry one data word in s_tdata; s_tlast
// marks the final word of a file. Words are taken as row-major blocks of
// ROWS x COLS words. Each row XOR and each column XOR is added, modulo
// 2^32, into a row sum and a column sum.
// Throughput is one word per cycle inside a block. The word that completes
// a block, or the word marked last, starts a walk over the column memory:
// a write-back state, a read of each column entry and a state for the
// final read data, with input held off throughout; after a last beat,
// input stays held off until the result is loaded for the m_ channel.
// The result sits in an output register; a new stream is accepted while it
// waits, and only the next result load waits for m_tready.
// Reset clears the counters, the sums, the row XOR and the valid bits of
// the column memory at once, so no clearing pass is needed.
module block_row_column_xor_checksum_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] row_sum, [63:32] col_sum
);

    typedef enum logic [4:0] {
        ST_RUN    = 5'b00001,
        ST_DRAIN  = 5'b00010,
        ST_FLUSH  = 5'b00100,
        ST_FINISH = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [rbcx_pkg::COL_W-1:0]  col_reg, col_next;
    logic [rbcx_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [rbcx_pkg::COL_W-1:0]  fl_cnt_reg, fl_cnt_next;
    logic                        last_pend_reg, last_pend_next;
    logic [rbcx_pkg::WORD_W-1:0] row_xor_reg, row_xor_next;
    logic [rbcx_pkg::WORD_W-1:0] row_total_reg, row_total_next;
    logic [rbcx_pkg::WORD_W-1:0] col_total_reg, col_total_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rbcx_pkg::WORD_W-1:0] out_row_reg, out_col_reg;

    logic                        accept;
    logic                        col_end;
    logic                        row_end;
    logic                        load_out;
    logic [rbcx_pkg::WORD_W-1:0] row_acc;

    rbcx_pkg::upd_req_t   upd;
    rbcx_pkg::flush_req_t fl_req;
    rbcx_pkg::flush_rsp_t fl_rsp;

    assign s_tready = (state_reg == ST_RUN);
    assign accept   = s_tvalid & s_tready;
    assign col_end  = (col_reg == rbcx_pkg::COL_W'(rbcx_pkg::COLS - 1));
    assign row_end  = (row_reg == rbcx_pkg::ROW_W'(rbcx_pkg::ROWS - 1));
    assign row_acc  = row_xor_reg ^ s_tdata;
    assign load_out = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign upd.valid = accept;
    assign upd.addr  = col_reg;
    assign upd.word  = s_tdata;

    assign fl_req.valid = (state_reg == ST_FLUSH);
    assign fl_req.addr  = fl_cnt_reg;

    rbcx_col_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd),
        .fl_req (fl_req),
        .fl_rsp (fl_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        fl_cnt_next    = fl_cnt_reg;
        last_pend_next = last_pend_reg;
        row_xor_next   = row_xor_reg;
        row_total_next = row_total_reg;
        col_total_next = col_total_reg;
        out_valid_next = out_valid_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        // Column entries come back from the memory one per cycle.
        if (fl_rsp.valid) begin
            col_total_next = col_total_reg + fl_rsp.data;
        end

        case (state_reg)
            ST_RUN: begin
                if (accept) begin
                    // A row closes at its last column or at the last word.
                    if (col_end || s_tlast) begin
                        row_total_next = row_total_reg + row_acc;
                        row_xor_next   = '0;
                    end
                    else begin
                        row_xor_next = row_acc;
                    end
                    if (s_tlast || (col_end && row_end)) begin
                        col_next       = '0;
                        row_next       = '0;
                        last_pend_next = s_tlast;
                        state_next     = ST_DRAIN;
                    end
                    else if (col_end) begin
                        col_next = '0;
                        row_next = row_reg + 1'b1;
                    end
                    else begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (fl_cnt_reg == rbcx_pkg::COL_W'(rbcx_pkg::COLS - 1)) begin
                    fl_cnt_next = '0;
                    state_next  = ST_FINISH;
                end
                else begin
                    fl_cnt_next = fl_cnt_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                state_next = last_pend_reg ? ST_EMIT : ST_RUN;
            end
            ST_EMIT: begin
                if (load_out) begin
                    out_valid_next = 1'b1;
                    last_pend_next = 1'b0;
                    row_total_next = '0;
                    col_total_next = '0;
                    state_next     = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_RUN;
            col_reg       <= '0;
            row_reg       <= '0;
            fl_cnt_reg    <= '0;
            last_pend_reg <= 1'b0;
            row_xor_reg   <= '0;
            row_total_reg <= '0;
            col_total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            fl_cnt_reg    <= fl_cnt_next;
            last_pend_reg <= last_pend_next;
            row_xor_reg   <= row_xor_next;
            row_total_reg <= row_total_next;
            col_total_reg <= col_total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result register holds its sums until the beat is taken.
    always_ff @(posedge clk) begin
        if (load_out) begin
            out_row_reg <= row_total_reg;
            out_col_reg <= col_total_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_col_reg, out_row_reg};

endmodule

### rtl/rbcx_checker.sv
`include "assert_macros.svh"

// Port-level checks of the checksum unit.
module rbcx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    `RBCX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `RBCX_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    `RBCX_ASSERT(a_flush_stall, s_tvalid && s_tready && s_tlast |-> ##(rbcx_pkg::COLS + 2) !s_tready, "input taken during the column flush")
    `RBCX_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !m_tvalid, "result beat shown during reset")

endmodule

bind block_row_column_xor_checksum_unit rbcx_checker u_rbcx_checker (.*);

### test/tb_block_row_column_xor_checksum_unit.sv
module tb_block_row_column_xor_checksum_unit;

    timeunit 1ns;
    timeprecision 1ps;

    // A stretch this long in which neither side moves a beat means the block has hung.
    // The slowest correct stretch is a column flush plus a random sender gap or receiver
    // stall, so this leaves a wide margin.
    localparam int STALL_LIMIT = 4000;
    localparam int BLOCK_WORDS = rbcx_pkg::ROWS * rbcx_pkg::COLS;

    // One row of the directed table. When known is set, the sums that the stream emits
    // on this word are typed in by hand. Otherwise the predictor supplies them.
    typedef struct packed {
        logic [rbcx_pkg::WORD_W-1:0] word;
        logic                        last;
        logic                        known;
        logic [rbcx_pkg::WORD_W-1:0] row_sum;
        logic [rbcx_pkg::WORD_W-1:0] col_sum;
    } word_row_t;

    typedef struct packed {
        logic [rbcx_pkg::WORD_W-1:0] row_sum;
        logic [rbcx_pkg::WORD_W-1:0] col_sum;
    } sum_pair_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] word
    logic        s_tlast  = 1'b0; // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [31:0] row_sum, [63:32] col_sum

    block_row_column_xor_checksum_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predictor state: this mirrors what the block should hold after reset and after
    // every stream that ended in a word marked last.
    logic [rbcx_pkg::WORD_W-1:0] col_acc [rbcx_pkg::COLS];
    logic [rbcx_pkg::WORD_W-1:0] row_acc   = '0;
    int                          blk_pos   = 0;
    logic [rbcx_pkg::WORD_W-1:0] row_total = '0;
    logic [rbcx_pkg::WORD_W-1:0] col_total = '0;

    // Sums that the block still owes on its result channel, oldest first.
    sum_pair_t sums_due [$];

    int errors         = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;

    initial
    begin
        foreach (col_acc[c])
        begin
            col_acc[c] = '0;
        end
    end

    task automatic report_mismatch(input string what,
                                   input logic [rbcx_pkg::WORD_W-1:0] got,
                                   input logic [rbcx_pkg::WORD_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %08h, expected %08h", $realtime, what, got, want);
        errors++;
    endtask

    // Adds every column XOR of the current block into the column sum and clears them.
    function automatic void flush_columns();
        for (int c = 0; c < rbcx_pkg::COLS; c++)
        begin
            col_total += col_acc[c];
            col_acc[c] = '0;
        end
    endfunction

    // Folds one accepted word into the running XORs and sums. Returns 1 when the word
    // closes a stream, with the two sums that the block has to emit.
    function automatic bit fold_word(input logic [rbcx_pkg::WORD_W-1:0] w,
                                     input logic is_last,
                                     output logic [rbcx_pkg::WORD_W-1:0] rs,
                                     output logic [rbcx_pkg::WORD_W-1:0] cs);
        int col;
        col = blk_pos % rbcx_pkg::COLS;
        rs  = '0;
        cs  = '0;
        row_acc      ^= w;
        col_acc[col] ^= w;
        // The word that fills the last column closes the row.
        if (col == rbcx_pkg::COLS - 1)
        begin
            row_total += row_acc;
            row_acc    = '0;
        end
        // The word that fills the last position closes the block.
        blk_pos++;
        if (blk_pos == BLOCK_WORDS)
        begin
            flush_columns();
            blk_pos = 0;
        end
        if (!is_last)
            return 1'b0;
        // A partial row or block is padded with zeros, so the pending XORs are simply
        // added as they stand. Afterwards everything starts over for the next stream.
        row_total += row_acc;
        flush_columns();
        rs        = row_total;
        cs        = col_total;
        row_acc   = '0;
        blk_pos   = 0;
        row_total = '0;
        col_total = '0;
        return 1'b1;
    endfunction

    // Presents one input beat, holds it until the block takes it, then predicts. The
    // valid line gets exactly one nonblocking assignment per time step: either it is
    // lowered for an idle cycle or it is raised for the beat.
    task automatic drive_word(input logic [rbcx_pkg::WORD_W-1:0] w, input logic is_last,
                              input logic known,
                              input logic [rbcx_pkg::WORD_W-1:0] known_row,
                              input logic [rbcx_pkg::WORD_W-1:0] known_col);
        logic [rbcx_pkg::WORD_W-1:0] rs;
        logic [rbcx_pkg::WORD_W-1:0] cs;
        sum_pair_t                   due;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (fold_word(w, is_last, rs, cs))
        begin
            due.row_sum = known ? known_row : rs;
            due.col_sum = known ? known_col : cs;
            sums_due.push_back(due);
        end
    endtask

    // Random word content, leaning now and then on the all-zero and all-one patterns.
    function automatic logic [rbcx_pkg::WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Result side: checks every accepted result beat against the oldest owed pair and
    // draws the ready line for the next cycle. Values read here are the ones that were
    // stable before this edge, since the block updates its registers nonblocking.
    always @(posedge clk)
    begin
        sum_pair_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sums_due.size() == 0)
            begin
                report_mismatch("result with nothing owed (row_sum)", m_tdata[31:0], '0);
            end
            else
            begin
                due = sums_due.pop_front();
                if (m_tdata[31:0] !== due.row_sum)
                    report_mismatch("row_sum", m_tdata[31:0], due.row_sum);
                if (m_tdata[63:32] !== due.col_sum)
                    report_mismatch("col_sum", m_tdata[63:32], due.col_sum);
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // The watchdog counts cycles in which no beat moves on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog: no beat accepted for %0d cycles", $realtime,
                         quiet_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Directed streams. Single-word streams put the word into both sums unchanged. Two
    // all-ones words in different columns cancel in the row XOR, while the column sum
    // wraps. The other short streams mix patterns and are left to the predictor.
    word_row_t dir_rows [0:12] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000},
        '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 32'h0000_0001},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 32'hFFFF_FFFE},
        '{32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'h5A5A_5A5A, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'h8000_0001, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000},
        '{32'hDEAD_BEEF, 1'b1, 1'b1, 32'hDEAD_BEEF, 32'hDEAD_BEEF}
    };

    // Stream lengths that land on a row end, just past a row end and just past a block
    // end come first in the random part, with random content.
    int edge_lengths [0:2] = '{rbcx_pkg::COLS, rbcx_pkg::COLS + 1, BLOCK_WORDS + 1};

    initial
    begin
        int streams_sent;
        int len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            drive_word(dir_rows[i].word, dir_rows[i].last, dir_rows[i].known,
                       dir_rows[i].row_sum, dir_rows[i].col_sum);
        end

        // Random streams. The idling pattern changes every four streams: none, sender
        // idle most of the time, receiver stalling most of the time, and light idling on
        // both sides. One stream runs just past a whole block so that a block flush
        // happens in the middle of a stream, two run for about one row, and the rest are
        // short so that results come often.
        streams_sent = 0;
        while (streams_sent < 16)
        begin
            case ((streams_sent / 4) % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            if (streams_sent < 3)
                len = edge_lengths[streams_sent];
            else
                len = $urandom_range(1, 12);
            for (int k = 1; k <= len; k++)
            begin
                drive_word(pick_word(), k == len, 1'b0, '0, '0);
            end
            streams_sent += 1;
        end

        s_tvalid <= 1'b0;
        src_idle_pct = 0;
        sink_stall_pct = 0;

        // Wait for every owed result, then give the block time to show any stray one.
        while (sums_due.size() != 0)
            @(posedge clk);
        repeat (rbcx_pkg::COLS + 12) @(posedge clk);

        if (errors == 0 && sums_due.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
